/* hdl/sxtc_pkg.sv */
// Shared types, codes and keyword tables for the s-expression tokenizer.
package sxtc_pkg;

    localparam int SXTC_QDEPTH = 4;
    localparam int SXTC_NUM_KW = 11;
    localparam int SXTC_WLEN_MAX = 6;

    typedef enum logic [2:0] {
        KIND_PAREN   = 3'd0,
        KIND_INT     = 3'd1,
        KIND_FLOAT   = 3'd2,
        KIND_STRING  = 3'd3,
        KIND_NIL     = 3'd4,
        KIND_BUILTIN = 3'd5,
        KIND_VAR     = 3'd6
    } t_kind;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'b001,
        MODE_WORD = 3'b010,
        MODE_STR  = 3'b100
    } t_mode;

    typedef struct packed {
        logic is_space;
        logic is_paren;
        logic is_quote;
        logic is_bslash;
        logic is_digit;
        logic is_fchar;
    } t_cls;

    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
        t_cls       cls;
    } t_item;

    // Keyword text, padded with zeros: nil, then the builtins in id order
    localparam logic [7:0] KW_TEXT [SXTC_NUM_KW][8] = '{
        '{"n", "i", "l", 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
        '{"s", "e", "t", 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
        '{"p", "r", "i", "n", "t", 8'd0, 8'd0, 8'd0},
        '{"r", "e", "a", "d", 8'd0, 8'd0, 8'd0, 8'd0},
        '{"+", 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
        '{"-", 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
        '{"*", 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
        '{"/", 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
        '{"c", "o", "n", "s", 8'd0, 8'd0, 8'd0, 8'd0},
        '{"c", "a", "r", 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
        '{"c", "d", "r", 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}
    };

    localparam logic [2:0] KW_LEN [SXTC_NUM_KW] = '{
        3'd3, 3'd3, 3'd5, 3'd4, 3'd1, 3'd1, 3'd1, 3'd1, 3'd4, 3'd3, 3'd3
    };

    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_LOW_E  = 8'h65;
    localparam logic [7:0] CH_UP_E   = 8'h45;

endpackage

/* hdl/sxtc_front.sv */
// Front end: classifies each incoming byte into a queue entry.
module sxtc_front import sxtc_pkg::*; (
    input  logic [7:0] i_ch,
    input  logic       i_end_of_text,
    output t_item      o_item
);

    logic w_digit;

    assign w_digit = (i_ch >= CH_ZERO) && (i_ch <= CH_NINE);

    always_comb begin
        o_item.ch            = i_ch;
        o_item.eot           = i_end_of_text;
        o_item.cls.is_space  = (i_ch == CH_SPACE) || ((i_ch >= CH_TAB) && (i_ch <= CH_CR));
        o_item.cls.is_paren  = (i_ch == CH_LPAREN) || (i_ch == CH_RPAREN);
        o_item.cls.is_quote  = (i_ch == CH_SQUOTE) || (i_ch == CH_DQUOTE);
        o_item.cls.is_bslash = (i_ch == CH_BSLASH);
        o_item.cls.is_digit  = w_digit;
        o_item.cls.is_fchar  = w_digit || (i_ch == CH_DOT) || (i_ch == CH_LOW_E)
                               || (i_ch == CH_UP_E);
    end

endmodule

/* hdl/sxtc_fifo.sv */
// Short queue between the classifying front end and the lexer back end.
module sxtc_fifo import sxtc_pkg::*; #(
    parameter int DEPTH = SXTC_QDEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_wr,
    input  t_item i_data,
    output logic  o_full,
    input  logic  i_rd,
    output logic  o_empty,
    output t_item o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item         r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          w_wr, w_rd;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_wr    = i_wr && !o_full;
    assign w_rd    = i_rd && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

/* hdl/sxtc_back.sv */
// Back end: lexer state machine, word classifier and result register.
module sxtc_back import sxtc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_empty,
    input  t_item      i_item,
    output logic       o_q_rd,
    output logic       o_empty,
    input  logic       i_pop,
    output logic [7:0] o_tok_byte,
    output logic       o_tok_first,
    output logic       o_tok_last,
    output logic [2:0] o_tok_kind,
    output logic [3:0] o_builtin_id
);

    t_mode                  r_mode, n_mode;
    logic [7:0]             r_held_byte, n_held_byte;
    logic                   r_held_valid, n_held_valid;
    logic                   r_held_first, n_held_first;
    logic [7:0]             r_closeq, n_closeq;
    logic                   r_esc, n_esc;
    logic [2:0]             r_wlen, n_wlen;
    logic                   r_dig, n_dig;
    logic                   r_flt, n_flt;
    logic [SXTC_NUM_KW-1:0] r_kw, n_kw;

    logic                   r_out_valid;
    logic [7:0]             r_out_byte;
    logic                   r_out_first;
    logic                   r_out_last;
    t_kind                  r_out_kind;
    logic [3:0]             r_out_id;

    logic                   w_fire, w_out_ready;
    logic                   w_emit, w_ofirst, w_olast;
    logic [7:0]             w_obyte;
    t_kind                  w_okind, w_wkind;
    logic [3:0]             w_oid, w_wid;

    logic [2:0]             w_base_len, w_tr_len;
    logic                   w_base_dig, w_base_flt, w_tr_dig, w_tr_flt;
    logic [SXTC_NUM_KW-1:0] w_base_kw, w_tr_kw;
    logic                   w_found;

    assign w_out_ready = !r_out_valid || i_pop;
    assign w_fire      = !i_q_empty && w_out_ready;
    assign o_q_rd      = w_fire;

    // Track the word with the current byte; a word that is starting begins cleared
    always_comb begin
        w_base_len = (r_mode == MODE_WORD) ? r_wlen : '0;
        w_base_dig = (r_mode == MODE_WORD) ? r_dig : 1'b1;
        w_base_flt = (r_mode == MODE_WORD) ? r_flt : 1'b1;
        w_base_kw  = (r_mode == MODE_WORD) ? r_kw : '1;
        for (int k = 0; k < SXTC_NUM_KW; k++) begin
            w_tr_kw[k] = w_base_kw[k] && (w_base_len < KW_LEN[k])
                         && (KW_TEXT[k][w_base_len] == i_item.ch);
        end
        w_tr_len = (w_base_len < 3'(SXTC_WLEN_MAX)) ? w_base_len + 3'd1 : w_base_len;
        w_tr_dig = w_base_dig && i_item.cls.is_digit;
        w_tr_flt = w_base_flt && i_item.cls.is_fchar;
    end

    // Class of the word tracked so far
    always_comb begin
        w_wkind = KIND_VAR;
        w_wid   = '0;
        w_found = 1'b0;
        if (r_dig) begin
            w_wkind = KIND_INT;
        end else if (r_flt) begin
            w_wkind = KIND_FLOAT;
        end else if (r_kw[0] && (r_wlen == KW_LEN[0])) begin
            w_wkind = KIND_NIL;
        end else begin
            for (int k = 1; k < SXTC_NUM_KW; k++) begin
                if (!w_found && r_kw[k] && (r_wlen == KW_LEN[k])) begin
                    w_found = 1'b1;
                    w_wkind = KIND_BUILTIN;
                    w_wid   = 4'(k - 1);
                end
            end
        end
    end

    always_comb begin
        n_mode       = r_mode;
        n_held_byte  = r_held_byte;
        n_held_valid = r_held_valid;
        n_held_first = r_held_first;
        n_closeq     = r_closeq;
        n_esc        = r_esc;
        n_wlen       = r_wlen;
        n_dig        = r_dig;
        n_flt        = r_flt;
        n_kw         = r_kw;
        w_emit       = 1'b0;
        w_obyte      = r_held_byte;
        w_ofirst     = r_held_first;
        w_olast      = 1'b0;
        w_okind      = KIND_PAREN;
        w_oid        = '0;
        if (w_fire) begin
            unique case (r_mode)
                MODE_WORD: begin
                    if (i_item.eot || i_item.cls.is_space) begin
                        if (r_held_valid) begin
                            w_emit  = 1'b1;
                            w_olast = 1'b1;
                            w_okind = w_wkind;
                            w_oid   = w_wid;
                        end
                        n_mode       = MODE_IDLE;
                        n_held_valid = 1'b0;
                        n_held_first = 1'b0;
                        n_esc        = 1'b0;
                        n_wlen       = '0;
                        n_dig        = 1'b1;
                        n_flt        = 1'b1;
                        n_kw         = '1;
                    end else begin
                        w_emit       = r_held_valid;
                        n_held_byte  = i_item.ch;
                        n_held_valid = 1'b1;
                        n_held_first = !r_held_valid;
                        n_wlen       = w_tr_len;
                        n_dig        = w_tr_dig;
                        n_flt        = w_tr_flt;
                        n_kw         = w_tr_kw;
                    end
                end
                MODE_STR: begin
                    if (!r_held_valid || i_item.eot || (!r_esc && (i_item.ch == r_closeq)))
                    begin
                        w_emit       = r_held_valid;
                        w_olast      = 1'b1;
                        w_okind      = KIND_STRING;
                        n_mode       = MODE_IDLE;
                        n_held_valid = 1'b0;
                        n_held_first = 1'b0;
                        n_esc        = 1'b0;
                        n_wlen       = '0;
                        n_dig        = 1'b1;
                        n_flt        = 1'b1;
                        n_kw         = '1;
                    end else begin
                        // An escaped byte is copied verbatim; after a backslash only end of text closes the string
                        w_emit       = 1'b1;
                        n_esc        = r_esc ? 1'b0 : i_item.cls.is_bslash;
                        n_held_byte  = i_item.ch;
                        n_held_valid = 1'b1;
                        n_held_first = 1'b0;
                    end
                end
                default: begin
                    n_mode = MODE_IDLE;
                    if (i_item.eot || i_item.cls.is_space) begin
                        n_mode = MODE_IDLE;
                    end else if (i_item.cls.is_paren) begin
                        w_emit   = 1'b1;
                        w_obyte  = i_item.ch;
                        w_ofirst = 1'b1;
                        w_olast  = 1'b1;
                    end else if (i_item.cls.is_quote) begin
                        n_mode       = MODE_STR;
                        n_closeq     = i_item.ch;
                        n_esc        = 1'b0;
                        n_held_byte  = i_item.ch;
                        n_held_valid = 1'b1;
                        n_held_first = 1'b1;
                    end else begin
                        n_mode       = MODE_WORD;
                        n_held_byte  = i_item.ch;
                        n_held_valid = 1'b1;
                        n_held_first = 1'b1;
                        n_wlen       = w_tr_len;
                        n_dig        = w_tr_dig;
                        n_flt        = w_tr_flt;
                        n_kw         = w_tr_kw;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_IDLE;
            r_held_valid <= 1'b0;
            r_held_first <= 1'b0;
            r_esc        <= 1'b0;
            r_wlen       <= '0;
            r_dig        <= 1'b1;
            r_flt        <= 1'b1;
            r_kw         <= '1;
            r_out_valid  <= 1'b0;
        end else begin
            r_mode       <= n_mode;
            r_held_valid <= n_held_valid;
            r_held_first <= n_held_first;
            r_esc        <= n_esc;
            r_wlen       <= n_wlen;
            r_dig        <= n_dig;
            r_flt        <= n_flt;
            r_kw         <= n_kw;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_held_byte <= n_held_byte;
        r_closeq    <= n_closeq;
        if (w_emit) begin
            r_out_byte  <= w_obyte;
            r_out_first <= w_ofirst;
            r_out_last  <= w_olast;
            r_out_kind  <= w_okind;
            r_out_id    <= w_oid;
        end
    end

    assign o_empty      = !r_out_valid;
    assign o_tok_byte   = r_out_byte;
    assign o_tok_first  = r_out_first;
    assign o_tok_last   = r_out_last;
    assign o_tok_kind   = r_out_kind;
    assign o_builtin_id = r_out_id;

endmodule

/* hdl/sexpr_tokenizer_classifier.sv */
// S-expression tokenizer top level: front classifier, byte queue, lexer back end.
// Throughput: one source byte per cycle unless full; the lexer retires one queue
// entry a cycle unless its result stalls. A paren passes the queue to the result
// register; word and string bytes leave when the next byte (or end of text) reaches
// the lexer. full rises only with QUEUE_DEPTH bytes queued behind a stalled result.
// Synchronous active-low reset empties the queue and the result register, lexer idle.
module sexpr_tokenizer_classifier import sxtc_pkg::*; #(
    parameter int QUEUE_DEPTH = SXTC_QDEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    output logic       o_full,
    input  logic [7:0] i_ch,
    input  logic       i_end_of_text,
    output logic       o_empty,
    input  logic       i_pop,
    output logic [7:0] o_tok_byte,
    output logic       o_tok_first,
    output logic       o_tok_last,
    output logic [2:0] o_tok_kind,
    output logic [3:0] o_builtin_id
);

    t_item w_in_item, w_q_item;
    logic  w_q_empty, w_q_rd;

    sxtc_front u_front (
        .i_ch          (i_ch),
        .i_end_of_text (i_end_of_text),
        .o_item        (w_in_item)
    );

    sxtc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_push),
        .i_data  (w_in_item),
        .o_full  (o_full),
        .i_rd    (w_q_rd),
        .o_empty (w_q_empty),
        .o_data  (w_q_item)
    );

    sxtc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (w_q_empty),
        .i_item       (w_q_item),
        .o_q_rd       (w_q_rd),
        .o_empty      (o_empty),
        .i_pop        (i_pop),
        .o_tok_byte   (o_tok_byte),
        .o_tok_first  (o_tok_first),
        .o_tok_last   (o_tok_last),
        .o_tok_kind   (o_tok_kind),
        .o_builtin_id (o_builtin_id)
    );

endmodule

/* hdl/sxtc_checker.sv */
// Port-level checks for the tokenizer, bound to the top level.
module sxtc_checker import sxtc_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_full,
    input logic       o_empty,
    input logic       i_pop,
    input logic [7:0] o_tok_byte,
    input logic       o_tok_first,
    input logic       o_tok_last,
    input logic [2:0] o_tok_kind,
    input logic [3:0] o_builtin_id
);

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> o_empty && !o_full)
        else $error("queues not empty after reset");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && !i_pop |=> !o_empty && $stable(o_tok_byte) && $stable(o_tok_first)
        && $stable(o_tok_last) && $stable(o_tok_kind) && $stable(o_builtin_id))
        else $error("waiting result changed before transfer");

    a_class_only_at_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && !o_tok_last |-> o_tok_kind == KIND_PAREN && o_builtin_id == 4'd0)
        else $error("class given on a byte that is not last");

    a_id_only_builtin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && o_tok_kind != KIND_BUILTIN |-> o_builtin_id == 4'd0)
        else $error("builtin id on a token of another kind");

    a_codes_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> o_tok_kind <= KIND_VAR && o_builtin_id <= 4'd9)
        else $error("kind or builtin id out of range");

endmodule

bind sexpr_tokenizer_classifier sxtc_checker u_sxtc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_full       (o_full),
    .o_empty      (o_empty),
    .i_pop        (i_pop),
    .o_tok_byte   (o_tok_byte),
    .o_tok_first  (o_tok_first),
    .o_tok_last   (o_tok_last),
    .o_tok_kind   (o_tok_kind),
    .o_builtin_id (o_builtin_id)
);
